FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the slot table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define DCST_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition must never be seen outside reset.
`define DCST_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/core/dcst_pkg.sv
// Types and constants of the destination command slot table.
package dcst_pkg;

	localparam int NUM_SLOTS_DEF = 16;
	localparam int IDX_OUT_W     = 4;
	localparam int IDX_MAX_W     = 8;

	localparam logic [1:0] OP_PUSH  = 2'd0;
	localparam logic [1:0] OP_CLEAN = 2'd1;
	localparam logic [1:0] OP_GET   = 2'd2;

	localparam logic [7:0] EMPTY_ADDR = 8'h00;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] dest_addr;
		logic [7:0] dest_bank;
		logic [7:0] cmd_length;
		logic [7:0] skip_count;
	} cmd_t;

	typedef struct packed {
		logic                 ok;
		logic [IDX_OUT_W-1:0] slot_index;
		logic [7:0]           slot_length;
	} rsp_t;

	typedef struct packed {
		logic [7:0] addr;
		logic [7:0] bank;
		logic [7:0] len;
	} entry_t;

	typedef struct packed {
		logic start;
		logic take;
	} seq_ctl_t;

	typedef struct packed {
		logic idle;
		logic done;
	} seq_stat_t;

endpackage

FILE: rtl/core/dcst_stream_if.sv
// Valid/ready stream channel carrying one payload item per transfer.
interface dcst_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: rtl/core/dcst_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dcst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/core/dcst_seq.sv
// Scan sequencer: walks the slot RAM once per command and evaluates each slot.
`include "assert_macros.svh"

module dcst_seq import dcst_pkg::*; #(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF,
	localparam int IW = $clog2(NUM_SLOTS)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  seq_ctl_t        ctl,
	input  cmd_t            cmd,
	output seq_stat_t       stat,
	output rsp_t            res,
	output logic            ram_re,
	output logic [IW-1:0]   ram_raddr,
	input  entry_t          ram_rdata,
	output logic            ram_we,
	output logic [IW-1:0]   ram_waddr,
	output entry_t          ram_wdata
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_DONE = 3'b100
	} state_t;

	localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SLOTS - 1);

	state_t               state_q;
	cmd_t                 cmd_q;
	logic [NUM_SLOTS-1:0] valid_q;
	logic                 issue_q;
	logic [IW-1:0]        rd_idx_q;
	logic                 vld_s1;
	logic [IW-1:0]        idx_s1;
	logic                 have_q, found_q;
	logic [IW-1:0]        pick_q, hit_idx_q;
	logic [7:0]           hit_len_q, skip_q;
	rsp_t                 res_q;

	logic                 have_n, found_n, clear_n, hit, last_s1;
	logic [IW-1:0]        pick_n, hit_idx_n;
	logic [7:0]           hit_len_n, skip_n, eff_addr;
	logic [IDX_MAX_W-1:0] idx_wide;
	rsp_t                 res_n;

	assign last_s1 = vld_s1 && (idx_s1 == LAST_IDX);

	// Evaluate the slot whose data returned from the RAM this cycle.
	always_comb begin
		eff_addr  = valid_q[idx_s1] ? ram_rdata.addr : EMPTY_ADDR;
		hit       = (eff_addr == cmd_q.dest_addr) && (ram_rdata.bank == cmd_q.dest_bank);
		have_n    = have_q;
		pick_n    = pick_q;
		found_n   = found_q;
		hit_idx_n = hit_idx_q;
		hit_len_n = hit_len_q;
		skip_n    = skip_q;
		clear_n   = 1'b0;
		if (vld_s1) begin
			unique case (cmd_q.opcode)
				OP_PUSH: begin
					// a later slot of the same destination voids an earlier free pick
					if (hit) begin
						have_n = 1'b0;
					end else if (!have_q && eff_addr == EMPTY_ADDR) begin
						have_n = 1'b1;
						pick_n = idx_s1;
					end
				end
				OP_CLEAN: begin
					clear_n = (eff_addr != cmd_q.dest_addr);
				end
				OP_GET: begin
					if (hit && !found_q) begin
						if (skip_q == 8'd0) begin
							found_n   = 1'b1;
							hit_idx_n = idx_s1;
							hit_len_n = ram_rdata.len;
						end else begin
							skip_n = skip_q - 8'd1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		res_n    = '0;
		idx_wide = '0;
		unique case (cmd_q.opcode)
			OP_PUSH: begin
				idx_wide   = IDX_MAX_W'(pick_n);
				res_n.ok   = have_n;
			end
			OP_CLEAN: begin
				res_n.ok = 1'b1;
			end
			OP_GET: begin
				idx_wide          = IDX_MAX_W'(hit_idx_n);
				res_n.ok          = found_n;
				res_n.slot_length = found_n ? hit_len_n : 8'd0;
			end
			default: begin
			end
		endcase
		res_n.slot_index = res_n.ok ? idx_wide[IDX_OUT_W-1:0] : '0;
	end

	assign ram_re    = (state_q == S_SCAN) && issue_q;
	assign ram_raddr = rd_idx_q;
	assign ram_we    = last_s1 && (cmd_q.opcode == OP_PUSH) && have_n;
	assign ram_waddr = pick_n;
	assign ram_wdata = '{addr: cmd_q.dest_addr, bank: cmd_q.dest_bank, len: cmd_q.cmd_length};

	assign stat.idle = (state_q == S_IDLE);
	assign stat.done = (state_q == S_DONE);
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			valid_q   <= '0;
			issue_q   <= 1'b0;
			rd_idx_q  <= '0;
			vld_s1    <= 1'b0;
			idx_s1    <= '0;
			have_q    <= 1'b0;
			found_q   <= 1'b0;
			pick_q    <= '0;
			hit_idx_q <= '0;
			skip_q    <= '0;
		end else begin
			vld_s1 <= ram_re;
			idx_s1 <= rd_idx_q;
			if (clear_n) begin
				valid_q[idx_s1] <= 1'b0;
			end
			if (ram_we) begin
				valid_q[pick_n] <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (ctl.start) begin
						state_q   <= S_SCAN;
						issue_q   <= 1'b1;
						rd_idx_q  <= '0;
						have_q    <= 1'b0;
						found_q   <= 1'b0;
						pick_q    <= '0;
						hit_idx_q <= '0;
						skip_q    <= cmd.skip_count;
					end
				end
				S_SCAN: begin
					if (issue_q) begin
						if (rd_idx_q == LAST_IDX) begin
							issue_q <= 1'b0;
						end else begin
							rd_idx_q <= rd_idx_q + 1'b1;
						end
					end
					have_q    <= have_n;
					pick_q    <= pick_n;
					found_q   <= found_n;
					hit_idx_q <= hit_idx_n;
					skip_q    <= skip_n;
					if (last_s1) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (ctl.take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers: no reset.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && ctl.start) begin
			cmd_q <= cmd;
		end
		if (state_q == S_SCAN) begin
			hit_len_q <= hit_len_n;
		end
		if (last_s1) begin
			res_q <= res_n;
		end
	end

	`DCST_CHECK(a_we_at_scan_end, ram_we |-> (state_q == S_SCAN && last_s1), "slot write outside scan end")
	`DCST_NEVER(a_s1_in_scan, vld_s1 && state_q != S_SCAN, "slot data returned outside scan")
	`DCST_CHECK(a_done_hold, (state_q == S_DONE && !ctl.take) |=> (state_q == S_DONE && $stable(res_q)), "result lost before transfer")
	`DCST_CHECK(a_push_marks_valid, ram_we |=> valid_q[$past(ram_waddr)], "pushed slot not marked valid")

endmodule

FILE: rtl/core/destination_command_slot_table_unit.sv
// A new command is taken only when the sequencer is idle after the last scan,
// which reads one slot per cycle through the single read port of the slot RAM.
// A finished response waits in an output register, so the next command is taken
// while it stalls. Reset marks every slot empty at once through per-slot valid bits;
// bank and length stay undefined until a push writes them.
`include "assert_macros.svh"

module destination_command_slot_table_unit import dcst_pkg::*; #(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	dcst_stream_if.sink  cmd,
	dcst_stream_if.source rsp
);

	localparam int IW = $clog2(NUM_SLOTS);

	seq_ctl_t      ctl;
	seq_stat_t     stat;
	rsp_t          res;
	logic          ram_re, ram_we;
	logic [IW-1:0] ram_raddr, ram_waddr;
	entry_t        ram_wdata, ram_rdata;
	logic          rsp_valid_q;
	rsp_t          rsp_data_q;

	assign cmd.ready = stat.idle;
	assign ctl.start = cmd.valid && stat.idle;
	// move a finished result into the output register once it is free
	assign ctl.take  = stat.done && (!rsp_valid_q || rsp.ready);

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctl.take) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take) begin
			rsp_data_q <= res;
		end
	end

	dcst_seq #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.cmd      (cmd.data),
		.stat     (stat),
		.res      (res),
		.ram_re   (ram_re),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata),
		.ram_we   (ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata)
	);

	dcst_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(NUM_SLOTS)
	) u_slot_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	`DCST_CHECK(a_busy_after_cmd, (cmd.valid && cmd.ready) |=> !cmd.ready, "second command taken during a scan")
	`DCST_NEVER(a_take_when_full, ctl.take && rsp_valid_q && !rsp.ready, "response register overwritten")

endmodule
